FILE: sv/tbca_pkg.sv
// ----------------------------------------------------------------------------
// tbca_pkg: shared types and constants for the beam-line closest approach core
// Request and result structs, status codes and the arithmetic widths
// used by the core, its long divider and its square root unit.
// ----------------------------------------------------------------------------
package tbca_pkg;

  localparam int TAG_W   = 10;
  localparam int COORD_W = 32;
  localparam int DIST_W  = 31;
  localparam int PROD_W  = 2 * COORD_W;

  // long divider: 128-bit numerator, 64-bit denominator, 62 quotient bits
  localparam int NUM_W   = 128;
  localparam int DEN_W   = 64;
  localparam int DIV_QW  = 62;
  localparam int DIV_LAT = DIV_QW + 1;

  // square root: 62-bit radicand, 31-bit root, one root bit per stage
  localparam int SQ_W     = 31;
  localparam int SQ_IN_W  = 2 * SQ_W;
  localparam int SQ_REM_W = SQ_W + 2;
  localparam int SQ_LAT   = SQ_W;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_PZ  = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]          track_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] mom_x;
    logic signed [COORD_W-1:0] mom_y;
    logic signed [COORD_W-1:0] mom_z;
  } tbca_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag_out;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] mid_z;
    logic [DIST_W-1:0]         distance;
    status_t                   status;
  } tbca_rsp_t;

endpackage

FILE: sv/tbca_div.sv
// ----------------------------------------------------------------------------
// tbca_div: pipelined restoring divider
// One quotient bit per stage. Flags a quotient that does not fit in
// DIV_QW bits; quotient and remainder are then meaningless.
// ----------------------------------------------------------------------------
module tbca_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tbca_pkg::NUM_W-1:0]   num,
  input  logic [tbca_pkg::DEN_W-1:0]   den,
  output logic [tbca_pkg::DIV_QW-1:0]  quo,
  output logic [tbca_pkg::DEN_W-1:0]   rem,
  output logic [tbca_pkg::DEN_W-1:0]   den_out,
  output logic                         ovf
);
  import tbca_pkg::*;

  localparam int HI_W = NUM_W - DIV_QW;

  logic [DEN_W-1:0]  rem_q [0:DIV_QW];
  logic [DIV_QW-1:0] nq_q  [0:DIV_QW];
  logic [DEN_W-1:0]  d_q   [0:DIV_QW];
  logic              ovf_q [0:DIV_QW];

  logic ovf_c;

  // quotient overflows when the upper numerator part reaches the divisor
  assign ovf_c = num[NUM_W-1 -: HI_W] >= HI_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0] <= ovf_c;
      rem_q[0] <= ovf_c ? '0 : num[DIV_QW +: DEN_W];
      nq_q[0]  <= num[DIV_QW-1:0];
      d_q[0]   <= den;
    end
  end

  // numerator bits shift out the top, quotient bits shift in the bottom
  for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
    logic [DEN_W:0] tmp;
    logic [DEN_W:0] dif;
    logic           ge;

    always_comb begin
      tmp = {rem_q[k], nq_q[k][DIV_QW-1]};
      dif = tmp - {1'b0, d_q[k]};
      ge  = tmp >= {1'b0, d_q[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? dif[DEN_W-1:0] : tmp[DEN_W-1:0];
        nq_q[k+1]  <= {nq_q[k][DIV_QW-2:0], ge};
        d_q[k+1]   <= d_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo     = nq_q[DIV_QW];
  assign rem     = rem_q[DIV_QW];
  assign den_out = d_q[DIV_QW];
  assign ovf     = ovf_q[DIV_QW];

endmodule

FILE: sv/tbca_sqrt.sv
// ----------------------------------------------------------------------------
// tbca_sqrt: pipelined integer square root
// Digit-by-digit restoring root, one root bit per stage: root = floor(sqrt(v)).
// ----------------------------------------------------------------------------
module tbca_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tbca_pkg::SQ_IN_W-1:0]  v,
  output logic [tbca_pkg::SQ_W-1:0]     root
);
  import tbca_pkg::*;

  logic [SQ_REM_W-1:0] rem_q  [0:SQ_W-1];
  logic [SQ_W-1:0]     root_q [0:SQ_W-1];
  logic [SQ_IN_W-1:0]  vv_q   [0:SQ_W-1];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_i;
    logic [SQ_W-1:0]     root_i;
    logic [SQ_IN_W-1:0]  vv_i;
    logic [SQ_REM_W+1:0] tmp;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] dif;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign vv_i   = v;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign vv_i   = vv_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    always_comb begin
      tmp   = {rem_i, vv_i[SQ_IN_W-1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      dif   = tmp - trial;
      ge    = tmp >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? dif[SQ_REM_W-1:0] : tmp[SQ_REM_W-1:0];
        root_q[k] <= {root_i[SQ_W-2:0], ge};
        vv_q[k]   <= {vv_i[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQ_W-1];

endmodule

FILE: sv/track_beamline_closest_approach_core.sv
// ----------------------------------------------------------------------------
// track_beamline_closest_approach_core: track to beam-line closest approach
// Midpoint and length of the shortest segment between a straight track and
// the z axis, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one track request (tag, point, momentum) per cycle, taken
//   when req_valid is high and req_stall is low.
//   rsp channel: one result per request, in request order, taken when
//   rsp_valid is high and rsp_stall is low.
//   Throughput: one request per cycle while req_stall is low.
//   Depth is set by five multiply/add stages, the 63-stage long dividers
//   (one quotient bit per stage), two rounding stages and the 31-stage
//   square root (one root bit per stage).
//   A two-entry result queue sits behind the pipeline; the whole pipeline
//   holds only when that queue is full, and req_stall is then high.
//   A receiver stall never drops or repeats a result.
//   Reset empties the pipeline and the queue; rsp_valid is low after reset.
//   Zero pz and tracks parallel to the beam give all-zero coordinates.
// ----------------------------------------------------------------------------
module track_beamline_closest_approach_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  tbca_pkg::tbca_req_t   req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output tbca_pkg::tbca_rsp_t   rsp
);
  import tbca_pkg::*;

  localparam logic [COORD_W-1:0] MID_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] MID_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam int TZ_W  = 35;
  localparam int ZS_W  = TZ_W + 2;
  localparam logic [DIV_QW:0] TZ_LIM = (DIV_QW+1)'(64'd1 << 34);

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] pos_z;
    status_t            pre;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
  } side_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] mid_x;
    logic [COORD_W-1:0] mid_y;
    logic [COORD_W-1:0] mid_z;
    status_t            pre;
    logic               sat;
    logic               dist_ovf;
  } mid_t;

  logic en;

  // -------- stage 1: products --------
  logic                      v1;
  logic [TAG_W-1:0]          tag1;
  logic [COORD_W-1:0]        z1;
  status_t                   pre1;
  logic signed [COORD_W-1:0] mx1, my1, mz1;
  logic signed [PROD_W-1:0]  p_xmy1, p_ymx1, p_xmx1, p_ymy1, p_mxmx1, p_mymy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1 <= req.track_id;
      z1   <= req.pos_z;
      if (req.mom_z == '0) begin
        pre1 <= ST_ZERO_PZ;
      end else if (req.mom_x == '0 && req.mom_y == '0) begin
        pre1 <= ST_PARALLEL;
      end else begin
        pre1 <= ST_OK;
      end
      mx1     <= req.mom_x;
      my1     <= req.mom_y;
      mz1     <= req.mom_z;
      p_xmy1  <= req.pos_x * req.mom_y;
      p_ymx1  <= req.pos_y * req.mom_x;
      p_xmx1  <= req.pos_x * req.mom_x;
      p_ymy1  <= req.pos_y * req.mom_y;
      p_mxmx1 <= req.mom_x * req.mom_x;
      p_mymy1 <= req.mom_y * req.mom_y;
    end
  end

  // -------- stage 2: cross term, dot term, squared transverse momentum --------
  logic                      v2;
  logic [TAG_W-1:0]          tag2;
  logic [COORD_W-1:0]        z2;
  status_t                   pre2;
  logic signed [COORD_W-1:0] mx2, my2, mz2;
  logic signed [PROD_W:0]    c2s, n2s;
  logic [DEN_W-1:0]          d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2 <= tag1;
      z2   <= z1;
      pre2 <= pre1;
      mx2  <= mx1;
      my2  <= my1;
      mz2  <= mz1;
      c2s  <= (PROD_W+1)'(p_xmy1) - (PROD_W+1)'(p_ymx1);
      n2s  <= (PROD_W+1)'(p_xmx1) + (PROD_W+1)'(p_ymy1);
      d2   <= DEN_W'($unsigned(p_mxmx1) + $unsigned(p_mymy1));
    end
  end

  // -------- stage 3: sign and magnitude --------
  logic               v3;
  logic [TAG_W-1:0]   tag3;
  logic [COORD_W-1:0] z3;
  status_t            pre3;
  logic [COORD_W-1:0] amx3, amy3, amz3;
  logic [DEN_W-1:0]   cmag3, nmag3, d3;
  logic               neg_x3, neg_y3, neg_z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3   <= tag2;
      z3     <= z2;
      pre3   <= pre2;
      d3     <= d2;
      amx3   <= mx2[COORD_W-1] ? COORD_W'(-mx2) : COORD_W'(mx2);
      amy3   <= my2[COORD_W-1] ? COORD_W'(-my2) : COORD_W'(my2);
      amz3   <= mz2[COORD_W-1] ? COORD_W'(-mz2) : COORD_W'(mz2);
      cmag3  <= c2s[PROD_W] ? DEN_W'(-c2s) : c2s[DEN_W-1:0];
      nmag3  <= n2s[PROD_W] ? DEN_W'(-n2s) : n2s[DEN_W-1:0];
      neg_x3 <= my2[COORD_W-1] ^ c2s[PROD_W];
      neg_y3 <= ~(mx2[COORD_W-1] ^ c2s[PROD_W]);
      neg_z3 <= mz2[COORD_W-1] ^ n2s[PROD_W];
    end
  end

  // -------- stage 4: 32x32 partial products --------
  logic             v4;
  side_t            side4;
  logic [DEN_W-1:0] d4;
  logic [63:0]      pxl4, pxh4, pyl4, pyh4, pzl4, pzh4, cll4, clh4, chh4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= '{tag: tag3, pos_z: z3, pre: pre3,
                 neg_x: neg_x3, neg_y: neg_y3, neg_z: neg_z3};
      d4    <= d3;
      pxl4  <= amy3 * cmag3[31:0];
      pxh4  <= amy3 * cmag3[63:32];
      pyl4  <= amx3 * cmag3[31:0];
      pyh4  <= amx3 * cmag3[63:32];
      pzl4  <= amz3 * nmag3[31:0];
      pzh4  <= amz3 * nmag3[63:32];
      cll4  <= cmag3[31:0] * cmag3[31:0];
      clh4  <= cmag3[31:0] * cmag3[63:32];
      chh4  <= cmag3[63:32] * cmag3[63:32];
    end
  end

  // -------- stage 5: combine partials into dividends --------
  logic             v5;
  side_t            side5;
  logic [DEN_W-1:0] d5;
  logic [NUM_W-1:0] nx5, ny5, nz5, nc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side4;
      d5    <= d4;
      nx5   <= NUM_W'(pxl4) + (NUM_W'(pxh4) << 32);
      ny5   <= NUM_W'(pyl4) + (NUM_W'(pyh4) << 32);
      nz5   <= NUM_W'(pzl4) + (NUM_W'(pzh4) << 32);
      nc5   <= {chh4, cll4} + (NUM_W'(clh4) << 33);
    end
  end

  // -------- long dividers --------
  logic [DIV_QW-1:0] qx, qy, qz, qc;
  logic [DEN_W-1:0]  remz, dz;
  logic              ovfz, ovfc;

  tbca_div u_div_x (
    .clk(clk), .en(en), .num(nx5), .den(d5),
    .quo(qx), .rem(), .den_out(), .ovf()
  );

  tbca_div u_div_y (
    .clk(clk), .en(en), .num(ny5), .den(d5),
    .quo(qy), .rem(), .den_out(), .ovf()
  );

  tbca_div u_div_z (
    .clk(clk), .en(en), .num(nz5), .den(d5),
    .quo(qz), .rem(remz), .den_out(dz), .ovf(ovfz)
  );

  tbca_div u_div_c (
    .clk(clk), .en(en), .num(nc5), .den(d5),
    .quo(qc), .rem(), .den_out(), .ovf(ovfc)
  );

  // side data and valid bits alongside the dividers
  side_t side_q [0:DIV_LAT-1];
  logic  vd_q   [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side5;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (en) begin
      vd_q[0] <= v5;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
    end
  end

  // -------- round 1: halve and round x, y; round z correction --------
  side_t             sd;
  logic [DIV_QW-1:0] hx, hy;
  logic [DIV_QW:0]   tz;
  logic              sat_x_c, sat_y_c, rnd_z;

  assign sd = side_q[DIV_LAT-1];

  always_comb begin
    hx      = DIV_QW'(({1'b0, qx} + (DIV_QW+1)'(1)) >> 1);
    hy      = DIV_QW'(({1'b0, qy} + (DIV_QW+1)'(1)) >> 1);
    sat_x_c = sd.neg_x ? (hx > DIV_QW'(MID_MIN)) : (hx > DIV_QW'(MID_MAX));
    sat_y_c = sd.neg_y ? (hy > DIV_QW'(MID_MIN)) : (hy > DIV_QW'(MID_MAX));
    rnd_z   = remz >= (dz - remz);
    tz      = {1'b0, qz} + (DIV_QW+1)'(rnd_z);
  end

  logic              r1_v;
  side_t             r1_side;
  logic [COORD_W-1:0] r1_mag_x, r1_mag_y;
  logic              r1_sat_x, r1_sat_y;
  logic [TZ_W-1:0]   r1_tz;
  logic              r1_big;
  logic [DIV_QW-1:0] r1_qc;
  logic              r1_ovfc;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
    end else if (en) begin
      r1_v <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_side  <= sd;
      r1_mag_x <= sat_x_c ? (sd.neg_x ? MID_MIN : MID_MAX) : hx[COORD_W-1:0];
      r1_mag_y <= sat_y_c ? (sd.neg_y ? MID_MIN : MID_MAX) : hy[COORD_W-1:0];
      r1_sat_x <= sat_x_c;
      r1_sat_y <= sat_y_c;
      r1_tz    <= tz[TZ_W-1:0];
      r1_big   <= ovfz | (tz > TZ_LIM);
      r1_qc    <= qc;
      r1_ovfc  <= ovfc;
    end
  end

  // -------- round 2: apply signs, add z correction, clip --------
  logic signed [ZS_W-1:0] z_ext, t_ext, z_sum;
  logic                   z_hi, z_lo;
  mid_t                   mid_c;

  always_comb begin
    z_ext = ZS_W'($signed(r1_side.pos_z));
    t_ext = $signed({2'b00, r1_tz});
    z_sum = r1_side.neg_z ? (z_ext + t_ext) : (z_ext - t_ext);
    z_hi  = z_sum > $signed({{(ZS_W-COORD_W){1'b0}}, MID_MAX});
    z_lo  = z_sum < $signed({{(ZS_W-COORD_W){1'b1}}, MID_MIN});

    mid_c.tag      = r1_side.tag;
    mid_c.pre      = r1_side.pre;
    mid_c.dist_ovf = r1_ovfc;
    mid_c.mid_x    = r1_side.neg_x ? COORD_W'(-r1_mag_x) : r1_mag_x;
    mid_c.mid_y    = r1_side.neg_y ? COORD_W'(-r1_mag_y) : r1_mag_y;
    if (r1_big) begin
      mid_c.mid_z = r1_side.neg_z ? MID_MAX : MID_MIN;
    end else if (z_hi) begin
      mid_c.mid_z = MID_MAX;
    end else if (z_lo) begin
      mid_c.mid_z = MID_MIN;
    end else begin
      mid_c.mid_z = z_sum[COORD_W-1:0];
    end
    mid_c.sat = r1_sat_x | r1_sat_y | r1_big | z_hi | z_lo;
  end

  logic              r2_v;
  mid_t              r2_mid;
  logic [DIV_QW-1:0] r2_qc;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_v <= 1'b0;
    end else if (en) begin
      r2_v <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_mid <= mid_c;
      r2_qc  <= r1_qc;
    end
  end

  // -------- square root of C^2/D, midpoint rides alongside --------
  logic [SQ_W-1:0] root;

  tbca_sqrt u_sqrt (
    .clk(clk), .en(en), .v(r2_qc[SQ_IN_W-1:0]), .root(root)
  );

  mid_t mid_q [0:SQ_LAT-1];
  logic vs_q  [0:SQ_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      mid_q[0] <= r2_mid;
      for (int i = 1; i < SQ_LAT; i++) begin
        mid_q[i] <= mid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQ_LAT; i++) begin
        vs_q[i] <= 1'b0;
      end
    end else if (en) begin
      vs_q[0] <= r2_v;
      for (int i = 1; i < SQ_LAT; i++) begin
        vs_q[i] <= vs_q[i-1];
      end
    end
  end

  // -------- result assembly --------
  mid_t      me;
  tbca_rsp_t res;

  assign me = mid_q[SQ_LAT-1];

  always_comb begin
    res.tag_out = me.tag;
    if (me.pre != ST_OK) begin
      res.mid_x    = '0;
      res.mid_y    = '0;
      res.mid_z    = '0;
      res.distance = '0;
      res.status   = me.pre;
    end else begin
      res.mid_x    = me.mid_x;
      res.mid_y    = me.mid_y;
      res.mid_z    = me.mid_z;
      res.distance = me.dist_ovf ? {DIST_W{1'b1}} : root[DIST_W-1:0];
      res.status   = (me.sat | me.dist_ovf) ? ST_SAT : ST_OK;
    end
  end

  // -------- two-entry result queue --------
  tbca_rsp_t buf_q [0:1];
  logic      wr_ptr, rd_ptr;
  logic [1:0] count;
  logic      push, pop;

  assign en        = (count != 2'd2);
  assign req_stall = ~en;
  assign push      = en & vs_q[SQ_LAT-1];
  assign rsp_valid = (count != 2'd0);
  assign pop       = rsp_valid & ~rsp_stall;
  assign rsp       = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: sv/tbca_checker.sv
// ----------------------------------------------------------------------------
// tbca_checker: port-level checks for the closest approach core
// Watches the request and result channels; bound to the core below.
// ----------------------------------------------------------------------------
module tbca_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input tbca_pkg::tbca_req_t  req,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input tbca_pkg::tbca_rsp_t  rsp
);
  import tbca_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // requests are held off only while results are waiting
  a_stall_backed: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no result pending");

  // degenerate tracks give zero coordinates and distance
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_ZERO_PZ || rsp.status == ST_PARALLEL) |->
      rsp.mid_x == '0 && rsp.mid_y == '0 && rsp.mid_z == '0 && rsp.distance == '0)
    else $error("degenerate track with nonzero result");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind track_beamline_closest_approach_core tbca_checker u_tbca_checker (.*);
